FILE: rtl/mwc_pkg.sv
// Shared types and constants for the maze wall carving block.
// Holds the request function codes, result status codes and wall bit masks.
// Has no dependencies.
package mwc_pkg;

    // Fixed field widths.
    localparam int IDX_W  = 10;
    localparam int DIM_W  = 6;
    localparam int PROD_W = 2 * DIM_W;

    // Divider step count: one quotient bit per step over the whole index.
    localparam int DIV_STEPS = IDX_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef logic [3:0]       wall_t;
    typedef logic [1:0]       func_t;
    typedef logic [1:0]       status_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [DIM_W-1:0] dim_t;

    // Request function codes; the unused code behaves as a read.
    localparam func_t FN_CLEAR = 2'd0;
    localparam func_t FN_CARVE = 2'd1;
    localparam func_t FN_READ  = 2'd2;

    // Result status codes.
    localparam status_t ST_CARVED  = 2'd0;
    localparam status_t ST_OUTSIDE = 2'd1;
    localparam status_t ST_NOT_ADJ = 2'd2;
    localparam status_t ST_DONE    = 2'd3;

    // Wall bits.
    localparam wall_t WALL_N    = 4'd1;
    localparam wall_t WALL_E    = 4'd2;
    localparam wall_t WALL_S    = 4'd4;
    localparam wall_t WALL_W    = 4'd8;
    localparam wall_t WALL_ALL  = 4'd15;
    localparam wall_t WALL_NONE = 4'd0;

    // Configuration register indexes.
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

endpackage

FILE: rtl/maze_wall_carve_from_edge_top.sv
// Top level of the maze wall carving block: wall store, index divider and sequencer.
// Depends on mwc_pkg for codes, widths and types.
// The store is an on-chip memory of MAX_CELLS four-bit entries.

// The block keeps one four-bit wall mask per maze cell and handles one request at a time.
// A clear request walks the store one cell a cycle, and the same sweep runs once after
// reset, during which no request is taken. A carve request splits both cell indices into
// row and column with one shared restoring divider, one index after the other, then
// checks adjacency and, for adjacent cells, does two read-modify-writes on the single
// write port of the store. A read request goes through the registered read port. A
// carve or read request that names a cell outside the grid goes straight to the result.
// A new request is taken while the previous result is still waiting at the output.
module maze_wall_carve_from_edge_top #(
    parameter int MAX_CELLS = 1024,
    parameter int MAX_DIM   = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Request channel.
    input  logic                  in_valid,
    output logic                  in_ready,
    input  mwc_pkg::func_t        func,
    input  mwc_pkg::idx_t         cell_a,
    input  mwc_pkg::idx_t         cell_b,
    // Result channel.
    output logic                  out_valid,
    input  logic                  out_ready,
    output mwc_pkg::wall_t        walls,
    output mwc_pkg::status_t      status,
    // Configuration write port.
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  mwc_pkg::dim_t         cfg_data
);

    localparam int AW = $clog2(MAX_CELLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CELLS - 1);

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_DIVA  = 4'd2;
    localparam logic [3:0] S_DIVB  = 4'd3;
    localparam logic [3:0] S_ADJ   = 4'd4;
    localparam logic [3:0] S_RDA   = 4'd5;
    localparam logic [3:0] S_WRA   = 4'd6;
    localparam logic [3:0] S_WRB   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // Registers.
    logic [3:0]                     state_reg, state_next;
    mwc_pkg::dim_t                  rows_reg, rows_next;
    mwc_pkg::dim_t                  cols_reg, cols_next;
    logic [AW-1:0]                  clr_ptr_reg, clr_ptr_next;
    logic                           clr_reply_reg, clr_reply_next;
    mwc_pkg::idx_t                  a_reg, a_next;
    mwc_pkg::idx_t                  b_reg, b_next;
    mwc_pkg::idx_t                  dvd_reg, dvd_next;
    mwc_pkg::dim_t                  rem_reg, rem_next;
    logic [mwc_pkg::STEP_W-1:0]     step_reg, step_next;
    mwc_pkg::idx_t                  ar_reg, ar_next;
    mwc_pkg::dim_t                  ac_reg, ac_next;
    mwc_pkg::wall_t                 ma_reg, ma_next;
    mwc_pkg::wall_t                 mb_reg, mb_next;
    logic                           adj_reg, adj_next;
    mwc_pkg::wall_t                 res_walls_reg, res_walls_next;
    mwc_pkg::status_t               res_status_reg, res_status_next;
    logic                           out_valid_reg, out_valid_next;
    mwc_pkg::wall_t                 out_walls_reg, out_walls_next;
    mwc_pkg::status_t               out_status_reg, out_status_next;
    mwc_pkg::wall_t                 rd_data_reg;

    // Wall store.
    mwc_pkg::wall_t                 wall_mem [MAX_CELLS];

    // Combinational signals.
    mwc_pkg::dim_t                  rows_eff, cols_eff;
    logic [mwc_pkg::PROD_W-1:0]     grid_cells;
    logic                           a_ok, b_ok;
    logic                           in_fire;
    logic [mwc_pkg::DIM_W:0]        trial;
    logic                           trial_ge;
    logic                           same_row, same_col;
    logic                           go_east, go_west, go_south, go_north;
    logic                           mem_we;
    logic [AW-1:0]                  wr_addr, rd_addr;
    mwc_pkg::wall_t                 wr_data;
    mwc_pkg::wall_t                 carved_a;

    // Effective grid size: dimensions capped at MAX_DIM, cells capped at MAX_CELLS.
    assign rows_eff = (32'(rows_reg) > MAX_DIM) ? mwc_pkg::DIM_W'(MAX_DIM) : rows_reg;
    assign cols_eff = (32'(cols_reg) > MAX_DIM) ? mwc_pkg::DIM_W'(MAX_DIM) : cols_reg;
    assign grid_cells = mwc_pkg::PROD_W'(rows_eff) * mwc_pkg::PROD_W'(cols_eff);

    // Range checks on the incoming indices.
    assign a_ok = ({2'b00, cell_a} < grid_cells) && (32'(cell_a) < MAX_CELLS);
    assign b_ok = ({2'b00, cell_b} < grid_cells) && (32'(cell_b) < MAX_CELLS);

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // One restoring division step: bring down the next dividend bit and try a subtract.
    assign trial    = {rem_reg, dvd_reg[mwc_pkg::IDX_W-1]};
    assign trial_ge = (trial >= {1'b0, cols_eff});

    // Adjacency of cell a (row ar_reg, column ac_reg) and cell b (quotient and remainder).
    assign same_row = (ar_reg == dvd_reg);
    assign same_col = (ac_reg == rem_reg);
    assign go_east  = same_row && ({1'b0, rem_reg} == {1'b0, ac_reg} + 7'd1);
    assign go_west  = same_row && ({1'b0, ac_reg} == {1'b0, rem_reg} + 7'd1);
    assign go_south = same_col && ({1'b0, dvd_reg} == {1'b0, ar_reg} + 11'd1);
    assign go_north = same_col && ({1'b0, ar_reg} == {1'b0, dvd_reg} + 11'd1);

    assign carved_a = rd_data_reg & ~ma_reg;

    // Store port control: clear sweep, or the two read-modify-writes of a carve.
    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = clr_ptr_reg;
        wr_data = mwc_pkg::WALL_ALL;
        rd_addr = AW'(a_reg);
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_WRA:
            begin
                mem_we  = adj_reg;
                wr_addr = AW'(a_reg);
                wr_data = carved_a;
                rd_addr = AW'(b_reg);
            end
            S_WRB:
            begin
                mem_we  = 1'b1;
                wr_addr = AW'(b_reg);
                wr_data = rd_data_reg & ~mb_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next      = state_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        clr_ptr_next    = clr_ptr_reg;
        clr_reply_next  = clr_reply_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        ar_next         = ar_reg;
        ac_next         = ac_reg;
        ma_next         = ma_reg;
        mb_next         = mb_reg;
        adj_next        = adj_reg;
        res_walls_next  = res_walls_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_walls_next  = out_walls_reg;
        out_status_next = out_status_reg;

        // Configuration writes.
        if (cfg_wr_en)
        begin
            if (cfg_index == mwc_pkg::REG_ROWS)
            begin
                rows_next = cfg_data;
            end
            else
            begin
                cols_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    a_next    = cell_a;
                    b_next    = cell_b;
                    dvd_next  = cell_a;
                    rem_next  = '0;
                    step_next = '0;
                    adj_next  = 1'b0;
                    if (func == mwc_pkg::FN_CLEAR)
                    begin
                        clr_ptr_next   = '0;
                        clr_reply_next = 1'b1;
                        state_next     = S_CLEAR;
                    end
                    else if (func == mwc_pkg::FN_CARVE)
                    begin
                        if (a_ok && b_ok)
                        begin
                            state_next = S_DIVA;
                        end
                        else
                        begin
                            res_walls_next  = mwc_pkg::WALL_NONE;
                            res_status_next = mwc_pkg::ST_OUTSIDE;
                            state_next      = S_DONE;
                        end
                    end
                    else
                    begin
                        if (a_ok)
                        begin
                            res_status_next = mwc_pkg::ST_DONE;
                            state_next      = S_RDA;
                        end
                        else
                        begin
                            res_walls_next  = mwc_pkg::WALL_NONE;
                            res_status_next = mwc_pkg::ST_OUTSIDE;
                            state_next      = S_DONE;
                        end
                    end
                end
            end
            S_CLEAR:
            begin
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == LAST_ADDR)
                begin
                    clr_ptr_next = '0;
                    if (clr_reply_reg)
                    begin
                        clr_reply_next  = 1'b0;
                        res_walls_next  = mwc_pkg::WALL_ALL;
                        res_status_next = mwc_pkg::ST_DONE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DIVA, S_DIVB:
            begin
                dvd_next  = {dvd_reg[mwc_pkg::IDX_W-2:0], trial_ge};
                rem_next  = trial_ge ? mwc_pkg::DIM_W'(trial - {1'b0, cols_eff})
                                     : mwc_pkg::DIM_W'(trial);
                step_next = step_reg + 1'b1;
                if (step_reg == mwc_pkg::STEP_W'(mwc_pkg::DIV_STEPS - 1))
                begin
                    step_next = '0;
                    if (state_reg == S_DIVA)
                    begin
                        // Row and column of cell a are kept; cell b goes through next.
                        ar_next    = {dvd_reg[mwc_pkg::IDX_W-2:0], trial_ge};
                        ac_next    = rem_next;
                        dvd_next   = b_reg;
                        rem_next   = '0;
                        state_next = S_DIVB;
                    end
                    else
                    begin
                        state_next = S_ADJ;
                    end
                end
            end
            S_ADJ:
            begin
                // Pick the facing walls of the two cells.
                adj_next   = 1'b1;
                ma_next    = mwc_pkg::WALL_NONE;
                mb_next    = mwc_pkg::WALL_NONE;
                res_status_next = mwc_pkg::ST_CARVED;
                if (go_east)
                begin
                    ma_next = mwc_pkg::WALL_E;
                    mb_next = mwc_pkg::WALL_W;
                end
                else if (go_west)
                begin
                    ma_next = mwc_pkg::WALL_W;
                    mb_next = mwc_pkg::WALL_E;
                end
                else if (go_south)
                begin
                    ma_next = mwc_pkg::WALL_S;
                    mb_next = mwc_pkg::WALL_N;
                end
                else if (go_north)
                begin
                    ma_next = mwc_pkg::WALL_N;
                    mb_next = mwc_pkg::WALL_S;
                end
                else
                begin
                    adj_next        = 1'b0;
                    res_status_next = mwc_pkg::ST_NOT_ADJ;
                end
                state_next = S_RDA;
            end
            S_RDA:
            begin
                state_next = S_WRA;
            end
            S_WRA:
            begin
                if (adj_reg)
                begin
                    res_walls_next = carved_a;
                    state_next     = S_WRB;
                end
                else
                begin
                    res_walls_next = rd_data_reg;
                    state_next     = S_DONE;
                end
            end
            S_WRB:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_walls_next  = res_walls_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers; a clearing sweep starts right after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rows_reg      <= mwc_pkg::DIM_W'(5);
            cols_reg      <= mwc_pkg::DIM_W'(5);
            clr_ptr_reg   <= '0;
            clr_reply_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            clr_ptr_reg   <= clr_ptr_next;
            clr_reply_reg <= clr_reply_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        ar_reg         <= ar_next;
        ac_reg         <= ac_next;
        ma_reg         <= ma_next;
        mb_reg         <= mb_next;
        adj_reg        <= adj_next;
        res_walls_reg  <= res_walls_next;
        res_status_reg <= res_status_next;
        out_walls_reg  <= out_walls_next;
        out_status_reg <= out_status_next;
    end

    // Wall store with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wall_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= wall_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign walls     = out_walls_reg;
    assign status    = out_status_reg;

    // A clearing sweep writes every cycle and keeps requests out.
    a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (mem_we && !in_ready))
        else $error("clear sweep not writing or taking requests");

    // The sweep pointer steps by one cell a cycle.
    a_clear_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clr_ptr_reg != LAST_ADDR)
        |=> (clr_ptr_reg == AW'($past(clr_ptr_reg) + 1'b1)))
        else $error("clear pointer skipped a cell");

    // The divider never runs past its last step.
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVA || state_reg == S_DIVB)
        |-> (step_reg <= mwc_pkg::STEP_W'(mwc_pkg::DIV_STEPS - 1)))
        else $error("divider step count out of range");

    // A carved cell has lost at least one wall.
    a_carved_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == mwc_pkg::ST_CARVED)
        |-> (out_walls_reg != mwc_pkg::WALL_ALL))
        else $error("carve reported with all walls standing");

endmodule
